// File: rtl/gmhd_pkg.sv
package gmhd_pkg;

    localparam int unsigned GridXCellsDef = 64;
    localparam int unsigned GridYCellsDef = 64;
    localparam logic [30:0] CellSizeReset = 31'd6554;

    // register addresses
    localparam logic [1:0] RegCellSize = 2'd0;

    localparam logic ModeInsert = 1'b0;
    localparam logic ModeDrain  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic        [31:0] in_attr;
    } t_in_word;

    typedef struct packed {
        logic               found;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic        [31:0] out_attr;
    } t_out_word;

endpackage

// File: rtl/gmhd_front.sv
module gmhd_front #(
    parameter int unsigned GRID_X_CELLS = 64,
    parameter int unsigned GRID_Y_CELLS = 64,
    localparam int unsigned AW = $clog2(GRID_X_CELLS * GRID_Y_CELLS),
    localparam int unsigned XW = $clog2(GRID_X_CELLS),
    localparam int unsigned YW = $clog2(GRID_Y_CELLS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [30:0]         i_cell_size,
    input  logic                i_valid,
    output logic                o_ready,
    input  gmhd_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_mode,
    output logic [AW-1:0]       o_addr,
    output logic [127:0]        o_data
);
    import gmhd_pkg::*;

    localparam logic [5:0] LastStep = 6'd32;

    // two restoring dividers (x and y) in lockstep, one quotient bit a cycle
    logic              r_busy, n_busy;
    logic [5:0]        r_step, n_step;
    logic [31:0]       r_den, n_den;
    logic [31:0]       r_qx, n_qx, r_qy, n_qy;
    logic [32:0]       r_rx, n_rx, r_ry, n_ry;
    logic              r_negx, n_negx, r_negy, n_negy;
    t_in_word          r_item, n_item;
    logic              r_ov, n_ov;
    logic              r_omode, n_omode;
    logic [AW-1:0]     r_oaddr, n_oaddr;
    logic [127:0]      r_odata, n_odata;

    logic [32:0] tx, ty;
    logic signed [33:0] colq, rowq;
    logic signed [33:0] col, row;
    logic [31:0] ax, ay;

    assign o_ready = !r_busy && (!r_ov || i_ready);
    assign o_valid = r_ov;
    assign o_mode  = r_omode;
    assign o_addr  = r_oaddr;
    assign o_data  = r_odata;

    always_comb begin
        ax = i_word.in_x[31] ? 32'(-i_word.in_x) : i_word.in_x;
        ay = i_word.in_y[31] ? 32'(-i_word.in_y) : i_word.in_y;
        tx = {r_rx[31:0], r_qx[31]};
        ty = {r_ry[31:0], r_qy[31]};
        // floor quotient: negative with remainder rounds down
        colq = r_negx ? -$signed({2'b0, r_qx}) - ((r_rx != '0) ? 34'sd1 : 34'sd0)
                      : $signed({2'b0, r_qx});
        rowq = r_negy ? -$signed({2'b0, r_qy}) - ((r_ry != '0) ? 34'sd1 : 34'sd0)
                      : $signed({2'b0, r_qy});
        col = colq + 34'(GRID_X_CELLS / 2);
        row = rowq + 34'(GRID_Y_CELLS / 2);
    end

    always_comb begin
        n_busy = r_busy; n_step = r_step; n_den = r_den;
        n_qx = r_qx; n_qy = r_qy; n_rx = r_rx; n_ry = r_ry;
        n_negx = r_negx; n_negy = r_negy; n_item = r_item;
        n_ov = r_ov; n_omode = r_omode; n_oaddr = r_oaddr; n_odata = r_odata;
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_item = i_word;
            if (i_word.mode == ModeDrain) begin
                n_ov = 1'b1;
                n_omode = ModeDrain;
            end else begin
                n_busy = 1'b1;
                n_step = '0;
                n_den = (i_cell_size == '0) ? 32'd1 : {1'b0, i_cell_size};
                n_qx = ax; n_qy = ay; n_rx = '0; n_ry = '0;
                n_negx = i_word.in_x[31];
                n_negy = i_word.in_y[31];
            end
        end else if (r_busy && r_step != LastStep) begin
            n_step = r_step + 6'd1;
            n_qx = {r_qx[30:0], 1'b0};
            n_qy = {r_qy[30:0], 1'b0};
            if (tx >= {1'b0, r_den}) begin
                n_rx = tx - {1'b0, r_den}; n_qx[0] = 1'b1;
            end else begin
                n_rx = tx;
            end
            if (ty >= {1'b0, r_den}) begin
                n_ry = ty - {1'b0, r_den}; n_qy[0] = 1'b1;
            end else begin
                n_ry = ty;
            end
        end else if (r_busy && !r_ov) begin
            // window check and address forming: row * GRID_X_CELLS + col
            n_busy = 1'b0;
            if (col >= 0 && col < 34'(GRID_X_CELLS) && row >= 0 &&
                row < 34'(GRID_Y_CELLS)) begin
                n_ov = 1'b1;
                n_omode = ModeInsert;
                n_oaddr = AW'(32'(row[YW-1:0]) * GRID_X_CELLS + 32'(col[XW-1:0]));
                n_odata = {r_item.in_attr, r_item.in_z, r_item.in_y, r_item.in_x};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ov   <= n_ov;
        end
        r_step <= n_step; r_den <= n_den;
        r_qx <= n_qx; r_qy <= n_qy; r_rx <= n_rx; r_ry <= n_ry;
        r_negx <= n_negx; r_negy <= n_negy; r_item <= n_item;
        r_omode <= n_omode; r_oaddr <= n_oaddr; r_odata <= n_odata;
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready) else $error("accept while dividing");
    a_div_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= LastStep) else $error("divider step overrun");
    a_drain_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_word.mode == ModeDrain) |=> (r_ov && r_omode == ModeDrain))
        else $error("drain not forwarded");
`endif
endmodule

// File: rtl/gmhd_back.sv
module gmhd_back #(
    parameter int unsigned GRID_X_CELLS = 64,
    parameter int unsigned GRID_Y_CELLS = 64,
    localparam int unsigned NCELL = GRID_X_CELLS * GRID_Y_CELLS,
    localparam int unsigned AW = $clog2(NCELL)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_mode,
    input  logic [AW-1:0]       i_addr,
    input  logic [127:0]        i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output gmhd_pkg::t_out_word o_word
);
    import gmhd_pkg::*;

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StRead  = 3'd1;
    localparam logic [2:0] StCmp   = 3'd2;
    localparam logic [2:0] StScan  = 3'd3;
    localparam logic [2:0] StCheck = 3'd4;
    localparam logic [2:0] StClear = 3'd5;

    // point store, occupancy bit on top of each entry; one registered read a cycle
    logic [128:0]     mem [NCELL];
    logic [128:0]     r_rd;
    logic [2:0]       r_st, n_st;
    logic [AW-1:0]    r_addr, n_addr;
    logic [127:0]     r_data, n_data;
    logic [AW-1:0]    r_cur, n_cur;
    logic [AW:0]      r_cnt, n_cnt;
    logic             r_ov, n_ov;
    t_out_word        r_out, n_out;
    logic             we;
    logic [AW-1:0]    wa, ra;
    logic [128:0]     wd;
    logic [AW-1:0]    nxt;

    assign o_ready = (r_st == StIdle);
    assign o_valid = r_ov;
    assign o_word  = r_out;
    assign nxt = (32'(r_cur) == NCELL - 1) ? '0 : r_cur + AW'(1);
    assign ra  = (r_st == StIdle) ? i_addr : ((r_st == StScan) ? r_cur : r_addr);

    always_comb begin
        n_st = r_st; n_addr = r_addr; n_data = r_data; n_cur = r_cur;
        n_cnt = r_cnt; n_ov = r_ov; n_out = r_out;
        we = 1'b0; wa = r_addr; wd = '0;
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
        unique case (r_st)
            StIdle: begin
                if (i_valid) begin
                    n_addr = i_addr;
                    n_data = i_data;
                    n_cnt = '0;
                    n_st = (i_mode == ModeDrain) ? StScan : StRead;
                end
            end
            StRead: n_st = StCmp;
            StCmp: begin
                if (!r_rd[128] ||
                    $signed(r_data[95:64]) > $signed(r_rd[95:64])) begin
                    we = 1'b1;
                    wd = {1'b1, r_data};
                end
                n_st = StIdle;
            end
            // read the cell under the cursor
            StScan: begin
                n_addr = r_cur;
                n_st = StCheck;
            end
            // emit and clear an occupied cell, else step on; after a full empty pass emit found = 0
            StCheck: begin
                if (r_rd[128]) begin
                    if (!r_ov) begin
                        n_out.found = 1'b1;
                        n_out.out_x = r_rd[31:0];
                        n_out.out_y = r_rd[63:32];
                        n_out.out_z = r_rd[95:64];
                        n_out.out_attr = r_rd[127:96];
                        n_ov = 1'b1;
                        we = 1'b1;
                        wd = {1'b0, r_rd[127:0]};
                        n_cur = nxt;
                        n_st = StIdle;
                    end
                end else if (32'(r_cnt) == NCELL - 1) begin
                    if (!r_ov) begin
                        n_out = '0;
                        n_ov = 1'b1;
                        n_cur = '0;
                        n_st = StIdle;
                    end
                end else begin
                    n_cur = nxt;
                    n_cnt = r_cnt + 1'b1;
                    n_st = StScan;
                end
            end
            // clearing pass after reset, one cell a cycle
            StClear: begin
                we = 1'b1;
                wa = r_cur;
                wd = '0;
                if (32'(r_cur) == NCELL - 1) begin
                    n_cur = '0;
                    n_st = StIdle;
                end else begin
                    n_cur = r_cur + AW'(1);
                end
            end
            default: n_st = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= StClear;
            r_cur <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cur <= n_cur;
            r_ov <= n_ov;
        end
        r_addr <= n_addr; r_data <= n_data; r_cnt <= n_cnt; r_out <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_new_cell_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == StCmp && !r_rd[128]) |-> (we && wd[128])) else $error("empty cell not filled");
    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == StCheck && r_rd[128] && !r_ov) |-> (we && !wd[128] && wa == r_addr))
        else $error("cell not cleared");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_out))) else $error("result changed");
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < NCELL) else $error("cursor out of range");
`endif
endmodule

// File: rtl/grid_max_height_downsample.sv
// grid max-height downsampler: keeps the highest point per grid cell
// config: APB-style port, register 0 at byte 0 is cell_size (31 bits);
//   the user must write it only while idle (the block does not enforce this); pready always high
// input words: mode 0 inserts a point, mode 1 drains the next occupied cell
// output words: one per drain; found = 0 with zero payload when store empty
// insert: a bit-serial divider (x and y together), then
//   read-compare-write in the point store
// drain: reads the store from the cursor, one cell per scan and check step;
//   with everything idle the result is valid once the cursor reaches an
//   occupied cell, or after one full pass over an empty store
// a two-word queue between front and back lets the divider run ahead
// reset: cursor to cell 0, then a clearing pass over all GRID_X_CELLS*GRID_Y_CELLS
//   cells empties the store; words wait in the front and queue meanwhile
// receiver stall: result held in the output register; the back end waits
//   only when a new result is ready while the old one is untaken
module grid_max_height_downsample #(
    parameter int unsigned GRID_X_CELLS = gmhd_pkg::GridXCellsDef,
    parameter int unsigned GRID_Y_CELLS = gmhd_pkg::GridYCellsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  gmhd_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output gmhd_pkg::t_out_word o_word
);
    import gmhd_pkg::*;

    localparam int unsigned AW = $clog2(GRID_X_CELLS * GRID_Y_CELLS);
    localparam int unsigned QW = AW + 129;

    logic [30:0] r_cell;
    logic           f_v, f_r, f_mode, b_r;
    logic [AW-1:0]  f_addr;
    logic [127:0]   f_data;
    logic [QW-1:0]  r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_n;

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr == RegCellSize) ? {1'b0, r_cell} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= CellSizeReset;
        end else if (psel && penable && pwrite && paddr == RegCellSize) begin
            r_cell <= pwdata[30:0];
        end
    end

    gmhd_front #(.GRID_X_CELLS(GRID_X_CELLS), .GRID_Y_CELLS(GRID_Y_CELLS)) u_front (
        .i_clk, .i_rst_n, .i_cell_size(r_cell), .i_valid, .o_ready, .i_word,
        .o_valid(f_v), .i_ready(f_r), .o_mode(f_mode), .o_addr(f_addr), .o_data(f_data)
    );

    // two-word queue between front and back
    assign f_r = (r_n != 2'd2);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_n <= '0;
        end else begin
            if (f_v && f_r) begin
                r_wp <= !r_wp;
            end
            if (r_n != 0 && b_r) begin
                r_rp <= !r_rp;
            end
            r_n <= r_n + 2'(f_v && f_r) - 2'(r_n != 0 && b_r);
        end
        if (f_v && f_r) begin
            r_q[r_wp] <= {f_mode, f_addr, f_data};
        end
    end

    gmhd_back #(.GRID_X_CELLS(GRID_X_CELLS), .GRID_Y_CELLS(GRID_Y_CELLS)) u_back (
        .i_clk, .i_rst_n, .i_valid(r_n != 0), .o_ready(b_r),
        .i_mode(r_q[r_rp][QW-1]), .i_addr(r_q[r_rp][QW-2:128]),
        .i_data(r_q[r_rp][127:0]), .o_valid, .i_ready, .o_word
    );

`ifndef NO_ASSERTIONS
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= 2'd2) else $error("queue overflow");
    a_q_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_n == 2'd0 || r_n == 2'd2) |-> (r_wp == r_rp)) else $error("queue pointers");
    a_q_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_n == 2'd2) |-> !f_r) else $error("push when full");
`endif
endmodule
